>>> sv/tlpq_pkg.sv
// Package for the two-level priority job queue.
// Shared types, request codes and sizes; no dependencies.
package tlpq_pkg;
    localparam int IMM_DEPTH = 4;
    localparam int STD_DEPTH = 8;
    localparam int IMM_AW = $clog2(IMM_DEPTH);
    localparam int STD_AW = $clog2(STD_DEPTH);
    localparam int CMDQ_DEPTH = 2;

    typedef enum logic [1:0] {
        REQ_ENQ    = 2'd0,
        REQ_DEQ    = 2'd1,
        REQ_PEEK   = 2'd2,
        REQ_SEARCH = 2'd3
    } t_req;

    typedef struct packed {
        logic [15:0] blk_id;
        logic [7:0]  service_id;
        logic [31:0] ram_addr;
        logic [7:0]  prio;
    } t_job;

    // classified command handed from front to back
    typedef struct packed {
        t_req req;
        logic to_imm;   // enqueue goes to the immediate ring
        logic sorted;   // enqueue is inserted by priority
        t_job job;
    } t_cmd;

    typedef struct packed {
        logic        status;
        logic [15:0] head_blk_id;
        logic [7:0]  head_service_id;
        logic [31:0] head_ram_addr;
        logic        from_immediate;
    } t_res;
endpackage

>>> sv/tlpq_front.sv
// Front end: takes requests, classifies enqueues against the mode register.
// Depends on tlpq_pkg.
module tlpq_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  logic [1:0]      i_req_type,
    input  logic [15:0]     i_blk_id,
    input  logic [7:0]      i_service_id,
    input  logic [31:0]     i_ram_addr,
    input  logic [7:0]      i_priority_req,
    input  logic            i_cfg_we,
    input  logic            i_cfg_data,
    output logic            o_cmd_valid,
    output tlpq_pkg::t_cmd  o_cmd
);
    logic r_prio_on;
    logic n_prio_on;

    always_comb begin
        n_prio_on = r_prio_on;
        if (i_cfg_we) begin
            n_prio_on = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio_on <= 1'b1;
        end else begin
            r_prio_on <= n_prio_on;
        end
    end

    assign o_cmd_valid = i_start && !i_busy;
    always_comb begin
        o_cmd.req            = tlpq_pkg::t_req'(i_req_type);
        o_cmd.job.blk_id     = i_blk_id;
        o_cmd.job.service_id = i_service_id;
        o_cmd.job.ram_addr   = i_ram_addr;
        o_cmd.job.prio       = i_priority_req;
        o_cmd.to_imm         = r_prio_on && (i_priority_req == 8'd0);
        o_cmd.sorted         = r_prio_on;
    end
endmodule

>>> sv/tlpq_cmdq.sv
// Small command queue between front and back ends.
// Depends on tlpq_pkg.
module tlpq_cmdq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tlpq_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output tlpq_pkg::t_cmd  o_cmd
);
    localparam int AW = $clog2(tlpq_pkg::CMDQ_DEPTH);
    tlpq_pkg::t_cmd r_mem [tlpq_pkg::CMDQ_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(tlpq_pkg::CMDQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(tlpq_pkg::CMDQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (AW+1)'(tlpq_pkg::CMDQ_DEPTH));
    assign o_cmd   = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("command queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("command queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(tlpq_pkg::CMDQ_DEPTH)) else $error("count out of range");
endmodule

>>> sv/tlpq_back.sv
// Back end: the two rings, sorted insertion walk and search walk.
// Depends on tlpq_pkg.
module tlpq_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  tlpq_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    output logic            o_res_valid,
    output tlpq_pkg::t_res  o_res
);
    localparam int IA = tlpq_pkg::IMM_AW;
    localparam int SA = tlpq_pkg::STD_AW;
    localparam int ID = tlpq_pkg::IMM_DEPTH;
    localparam int SD = tlpq_pkg::STD_DEPTH;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_INS  = 4'b0010,
        ST_SRCH = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    tlpq_pkg::t_job r_imm [ID];
    tlpq_pkg::t_job r_std [SD];
    logic [IA-1:0] r_ih, r_it;
    logic r_ie, r_if;
    logic [SA-1:0] r_sh, r_st;
    logic r_se, r_sf;

    tlpq_pkg::t_cmd r_cmd;
    logic [SA-1:0]  r_idx;      // walk position in the standard ring
    logic [IA:0]    r_icnt;     // immediate entries still to search
    logic [SA:0]    r_scnt;     // standard entries still to search
    logic [IA-1:0]  r_iidx;
    logic           r_found;
    tlpq_pkg::t_res r_res;
    tlpq_pkg::t_res n_res;
    logic           r_res_valid;

    function automatic logic [IA-1:0] inc_i(input logic [IA-1:0] v);
        return (v == IA'(ID - 1)) ? '0 : v + 1'b1;
    endfunction
    function automatic logic [SA-1:0] inc_s(input logic [SA-1:0] v);
        return (v == SA'(SD - 1)) ? '0 : v + 1'b1;
    endfunction
    function automatic logic [SA-1:0] dec_s(input logic [SA-1:0] v);
        return (v == '0) ? SA'(SD - 1) : v - 1'b1;
    endfunction

    logic [IA:0] w_icount;
    logic [SA:0] w_scount;
    logic [SA-1:0] w_prev;
    always_comb begin
        if (r_if) w_icount = (IA+1)'(ID);
        else if (r_ie) w_icount = '0;
        else if (r_it >= r_ih) w_icount = (IA+1)'(r_it) - (IA+1)'(r_ih);
        else w_icount = (IA+1)'(r_it) + (IA+1)'(ID) - (IA+1)'(r_ih);
        if (r_sf) w_scount = (SA+1)'(SD);
        else if (r_se) w_scount = '0;
        else if (r_st >= r_sh) w_scount = (SA+1)'(r_st) - (SA+1)'(r_sh);
        else w_scount = (SA+1)'(r_st) + (SA+1)'(SD) - (SA+1)'(r_sh);
        w_prev = dec_s(r_idx);
    end

    // result and next state for a command taken in idle
    always_comb begin
        n_res        = '0;
        n_res.status = 1'b1;
        n_state      = ST_DONE;
        if (i_cmd_valid) begin
            unique case (i_cmd.req)
                tlpq_pkg::REQ_ENQ: begin
                    if (i_cmd.to_imm) begin
                        n_res.status = r_if;
                    end else if (!r_sf) begin
                        if (r_se || !i_cmd.sorted) begin
                            n_res.status = 1'b0;
                        end else begin
                            n_state = ST_INS;
                        end
                    end
                end
                tlpq_pkg::REQ_DEQ: begin
                    if (!r_ie) begin
                        n_res.status         = 1'b0;
                        n_res.from_immediate = 1'b1;
                    end else if (!r_se) begin
                        n_res.status = 1'b0;
                    end
                end
                tlpq_pkg::REQ_PEEK: begin
                    if (!r_ie) begin
                        n_res.status          = 1'b0;
                        n_res.from_immediate  = 1'b1;
                        n_res.head_blk_id     = r_imm[r_ih].blk_id;
                        n_res.head_service_id = r_imm[r_ih].service_id;
                        n_res.head_ram_addr   = r_imm[r_ih].ram_addr;
                    end else if (!r_se) begin
                        n_res.status          = 1'b0;
                        n_res.head_blk_id     = r_std[r_sh].blk_id;
                        n_res.head_service_id = r_std[r_sh].service_id;
                        n_res.head_ram_addr   = r_std[r_sh].ram_addr;
                    end
                end
                tlpq_pkg::REQ_SEARCH: begin
                    n_state = ST_SRCH;
                end
                default: ;
            endcase
        end
    end

    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ih <= '0; r_it <= '0; r_ie <= 1'b1; r_if <= 1'b0;
            r_sh <= '0; r_st <= '0; r_se <= 1'b1; r_sf <= 1'b0;
            r_res_valid <= 1'b0;
            for (int k = 0; k < ID; k++) r_imm[k] <= '0;
            for (int k = 0; k < SD; k++) r_std[k] <= '0;
        end else begin
            r_res_valid <= (r_state == ST_DONE);
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_res   <= n_res;
                        r_state <= n_state;
                        unique case (i_cmd.req)
                            tlpq_pkg::REQ_ENQ: begin
                                if (i_cmd.to_imm) begin
                                    if (!r_if) begin
                                        r_imm[r_it] <= i_cmd.job;
                                        r_ie <= 1'b0;
                                        r_it <= inc_i(r_it);
                                        r_if <= (inc_i(r_it) == r_ih);
                                    end
                                end else if (!r_sf) begin
                                    if (r_se || !i_cmd.sorted) begin
                                        r_std[r_st] <= i_cmd.job;
                                        r_se <= 1'b0;
                                        r_st <= inc_s(r_st);
                                        r_sf <= (inc_s(r_st) == r_sh);
                                    end else begin
                                        r_idx <= r_st;
                                    end
                                end
                            end
                            tlpq_pkg::REQ_DEQ: begin
                                if (!r_ie) begin
                                    r_imm[r_ih] <= '0;
                                    r_if <= 1'b0;
                                    r_ih <= inc_i(r_ih);
                                    r_ie <= (inc_i(r_ih) == r_it);
                                end else if (!r_se) begin
                                    r_std[r_sh] <= '0;
                                    r_sf <= 1'b0;
                                    r_sh <= inc_s(r_sh);
                                    r_se <= (inc_s(r_sh) == r_st);
                                end
                            end
                            tlpq_pkg::REQ_PEEK: ;
                            tlpq_pkg::REQ_SEARCH: begin
                                r_icnt  <= w_icount;
                                r_scnt  <= w_scount;
                                r_iidx  <= r_ih;
                                r_idx   <= r_sh;
                                r_found <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_INS: begin
                    // one shift per cycle, from the tail back towards the head
                    if (r_idx != r_sh && r_cmd.job.prio < r_std[w_prev].prio) begin
                        r_std[r_idx] <= r_std[w_prev];
                        r_idx <= w_prev;
                    end else begin
                        r_std[r_idx] <= r_cmd.job;
                        r_se <= 1'b0;
                        r_st <= inc_s(r_st);
                        r_sf <= (inc_s(r_st) == r_sh);
                        r_res.status <= 1'b0;
                        r_state <= ST_DONE;
                    end
                end
                ST_SRCH: begin
                    // one entry per cycle: immediate ring first, then standard
                    if (r_found) begin
                        r_res.status <= 1'b0;
                        r_state <= ST_DONE;
                    end else if (r_icnt != '0) begin
                        r_found <= (r_imm[r_iidx].blk_id == r_cmd.job.blk_id);
                        r_iidx  <= inc_i(r_iidx);
                        r_icnt  <= r_icnt - 1'b1;
                    end else if (r_scnt != '0) begin
                        r_found <= (r_std[r_idx].blk_id == r_cmd.job.blk_id);
                        r_idx   <= inc_s(r_idx);
                        r_scnt  <= r_scnt - 1'b1;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_sf && r_se) && !(r_if && r_ie)) else $error("ring both full and empty");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_state != ST_IDLE)) else $error("command lost");
    a_res_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> o_res_valid) else $error("result missing");
    a_ins_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS) |-> !r_sf && !r_se) else $error("insert on bad ring");
endmodule

>>> sv/two_level_priority_job_queue.sv
// Top level of the two-level priority job queue.
// Depends on tlpq_pkg, tlpq_front, tlpq_cmdq, tlpq_back.
//
// Usage:
//   Request channel: drive i_req_type and the job fields with i_start high;
//   the request is taken at a clock edge where o_busy is low. Requests are
//   enqueue, dequeue, peek and search by block id.
//   Result: o_done is high for exactly one cycle with status, head job and
//   from_immediate. The receiver cannot stall; it must take it then.
//   Configuration: i_cfg_valid / o_cfg_ready write prioritization_on; write
//   only while no request is outstanding.
// Path: an accepted request is written to the command queue, popped by the
//   back end in idle, then passes its done state before the result register
//   raises o_done. A sorted enqueue walks the standard ring one shift per cycle;
//   a search checks one entry per cycle over both rings and stops on a hit.
//   Only the back end walks, one request at a time.
// Throughput: one request at a time; o_busy stays high from acceptance
//   through the o_done cycle, so the next request is taken in the cycle
//   after it at the earliest.
// Reset: both rings empty and cleared, prioritization on.
module two_level_priority_job_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_blk_id,
    input  logic [7:0]  i_service_id,
    input  logic [31:0] i_ram_addr,
    input  logic [7:0]  i_priority_req,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    output logic        o_done,
    output logic        o_status,
    output logic [15:0] o_head_blk_id,
    output logic [7:0]  o_head_service_id,
    output logic [31:0] o_head_ram_addr,
    output logic        o_from_immediate
);
    logic            w_cmd_valid;
    tlpq_pkg::t_cmd  w_cmd;
    logic            w_q_valid, w_q_full, w_pop;
    tlpq_pkg::t_cmd  w_q_cmd;
    tlpq_pkg::t_res  w_res;
    logic            w_res_valid;
    logic            r_pending;   // request accepted, result not yet shown

    assign o_busy      = r_pending || w_q_full;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (w_cmd_valid) begin
            r_pending <= 1'b1;
        end else if (w_res_valid) begin
            r_pending <= 1'b0;
        end
    end

    tlpq_front u_front (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy),
        .i_req_type, .i_blk_id, .i_service_id, .i_ram_addr, .i_priority_req,
        .i_cfg_we(i_cfg_valid && o_cfg_ready), .i_cfg_data,
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd)
    );

    tlpq_cmdq u_cmdq (
        .i_clk, .i_rst_n, .i_push(w_cmd_valid), .i_cmd(w_cmd),
        .i_pop(w_pop), .o_valid(w_q_valid), .o_full(w_q_full), .o_cmd(w_q_cmd)
    );

    tlpq_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_q_valid), .i_cmd(w_q_cmd),
        .o_cmd_pop(w_pop), .o_res_valid(w_res_valid), .o_res(w_res)
    );

    assign o_done            = w_res_valid;
    assign o_status          = w_res.status;
    assign o_head_blk_id     = w_res.head_blk_id;
    assign o_head_service_id = w_res.head_service_id;
    assign o_head_ram_addr   = w_res.head_ram_addr;
    assign o_from_immediate  = w_res.from_immediate;

    a_one_outstanding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_valid |=> o_busy) else $error("second request taken");
    a_done_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_pending) else $error("result without request");
    a_no_accept_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !w_cmd_valid) else $error("accept during result");
endmodule

>>> tb/sv/testbench.sv
// Testbench for the two-level priority job queue: directed and random requests,
// checked against an in-bench model of both rings. Depends on tlpq_pkg and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Scoreboard: keeps its own copy of both rings and the mode bit, predicts the
    // response of every accepted request and compares each o_done strobe with it.
    class job_queue_scoreboard;
        tlpq_pkg::t_job  imm_ring [tlpq_pkg::IMM_DEPTH];
        int    imm_rd, imm_wr;
        bit    imm_is_empty, imm_is_full;
        tlpq_pkg::t_job  std_ring [tlpq_pkg::STD_DEPTH];
        int    std_rd, std_wr;
        bit    std_is_empty, std_is_full;
        bit    prio_mode;
        tlpq_pkg::t_res  awaited [$];
        int    mismatches;
        int    checked;
        int    req_seen [4];

        function new();
            prio_mode    = 1'b1;
            imm_is_empty = 1'b1;
            std_is_empty = 1'b1;
            foreach (imm_ring[i]) imm_ring[i] = '0;
            foreach (std_ring[i]) std_ring[i] = '0;
        endfunction

        function void set_mode(bit v);
            prio_mode = v;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function int fill(int rd, int wr, bit e, bit f, int depth);
            if (f) return depth;
            if (e) return 0;
            return (wr >= rd) ? wr - rd : wr + depth - rd;
        endfunction

        function bit place_job(tlpq_pkg::t_job j);
            int pos, prv;
            if (prio_mode && j.prio == 8'd0) begin
                if (imm_is_full) return 1'b0;
                imm_ring[imm_wr] = j;
                imm_is_empty = 1'b0;
                imm_wr = (imm_wr + 1) % tlpq_pkg::IMM_DEPTH;
                if (imm_wr == imm_rd) imm_is_full = 1'b1;
                return 1'b1;
            end
            if (std_is_full) return 1'b0;
            pos = std_wr;
            if (prio_mode && !std_is_empty) begin
                // shift lower-ranked jobs back one slot; equal priority keeps order
                while (pos != std_rd) begin
                    prv = (pos == 0) ? tlpq_pkg::STD_DEPTH - 1 : pos - 1;
                    if (j.prio < std_ring[prv].prio) begin
                        std_ring[pos] = std_ring[prv];
                        pos = prv;
                    end else begin
                        break;
                    end
                end
            end
            std_ring[pos] = j;
            std_is_empty = 1'b0;
            std_wr = (std_wr + 1) % tlpq_pkg::STD_DEPTH;
            if (std_wr == std_rd) std_is_full = 1'b1;
            return 1'b1;
        endfunction

        // note an accepted request and queue the response it must produce
        function void note_request(tlpq_pkg::t_req rq, tlpq_pkg::t_job j);
            tlpq_pkg::t_res r;
            int   idx, n;
            r = '0;
            r.status = 1'b1;
            req_seen[rq]++;
            case (rq)
                tlpq_pkg::REQ_ENQ: r.status = !place_job(j);
                tlpq_pkg::REQ_DEQ: begin
                    if (!imm_is_empty) begin
                        imm_ring[imm_rd] = '0;
                        imm_is_full = 1'b0;
                        imm_rd = (imm_rd + 1) % tlpq_pkg::IMM_DEPTH;
                        if (imm_rd == imm_wr) imm_is_empty = 1'b1;
                        r.status = 1'b0;
                        r.from_immediate = 1'b1;
                    end else if (!std_is_empty) begin
                        std_ring[std_rd] = '0;
                        std_is_full = 1'b0;
                        std_rd = (std_rd + 1) % tlpq_pkg::STD_DEPTH;
                        if (std_rd == std_wr) std_is_empty = 1'b1;
                        r.status = 1'b0;
                    end
                end
                tlpq_pkg::REQ_PEEK: begin
                    if (!imm_is_empty) begin
                        r.status          = 1'b0;
                        r.from_immediate  = 1'b1;
                        r.head_blk_id     = imm_ring[imm_rd].blk_id;
                        r.head_service_id = imm_ring[imm_rd].service_id;
                        r.head_ram_addr   = imm_ring[imm_rd].ram_addr;
                    end else if (!std_is_empty) begin
                        r.status          = 1'b0;
                        r.head_blk_id     = std_ring[std_rd].blk_id;
                        r.head_service_id = std_ring[std_rd].service_id;
                        r.head_ram_addr   = std_ring[std_rd].ram_addr;
                    end
                end
                default: begin
                    n = fill(imm_rd, imm_wr, imm_is_empty, imm_is_full,
                             tlpq_pkg::IMM_DEPTH);
                    for (int k = 0; k < n; k++) begin
                        idx = (imm_rd + k) % tlpq_pkg::IMM_DEPTH;
                        if (imm_ring[idx].blk_id == j.blk_id) r.status = 1'b0;
                    end
                    n = fill(std_rd, std_wr, std_is_empty, std_is_full,
                             tlpq_pkg::STD_DEPTH);
                    for (int k = 0; k < n; k++) begin
                        idx = (std_rd + k) % tlpq_pkg::STD_DEPTH;
                        if (std_ring[idx].blk_id == j.blk_id) r.status = 1'b0;
                    end
                end
            endcase
            awaited.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("[%0t] response %0d: %s got %0h want %0h", $time, checked, what, got, want);
            mismatches++;
        endtask

        task check_result(tlpq_pkg::t_res got);
            tlpq_pkg::t_res want;
            if (awaited.size() == 0) begin
                report("response with no request outstanding", 32'd1, 32'd0);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                report("status", 32'(got.status), 32'(want.status));
            if (got.head_blk_id !== want.head_blk_id)
                report("head_blk_id", 32'(got.head_blk_id), 32'(want.head_blk_id));
            if (got.head_service_id !== want.head_service_id)
                report("head_service_id", 32'(got.head_service_id),
                       32'(want.head_service_id));
            if (got.head_ram_addr !== want.head_ram_addr)
                report("head_ram_addr", got.head_ram_addr, want.head_ram_addr);
            if (got.from_immediate !== want.from_immediate)
                report("from_immediate", 32'(got.from_immediate),
                       32'(want.from_immediate));
            checked++;
        endtask
    endclass

    localparam int STALL_LIMIT = 2000;   // idle cycles before the watchdog trips

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [1:0]  i_req_type = '0;
    logic [15:0] i_blk_id = '0;
    logic [7:0]  i_service_id = '0;
    logic [31:0] i_ram_addr = '0;
    logic [7:0]  i_priority_req = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;
    logic        o_done;
    logic        o_status;
    logic [15:0] o_head_blk_id;
    logic [7:0]  o_head_service_id;
    logic [31:0] o_head_ram_addr;
    logic        o_from_immediate;

    job_queue_scoreboard sb = new();
    int idle_pct;          // chance in a hundred that the sender pauses after a request
    int stall_cycles;
    int mode_writes;

    two_level_priority_job_queue DUT (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Response capture and watchdog. Values are read at the edge, before the
    // block's own updates land, so the cycle that ends here is what is seen.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                sb.check_result('{o_status, o_head_blk_id, o_head_service_id,
                                  o_head_ram_addr, o_from_immediate});
            if (o_done || (i_start && !o_busy) || (i_cfg_valid && o_cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end else begin
            stall_cycles <= 0;
        end
    end

    // Present one request and hold it until taken. i_start is left high so a
    // following request goes straight out; pauses lower it explicitly.
    task send_request(tlpq_pkg::t_req rq, logic [15:0] bid, logic [7:0] sid,
                      logic [31:0] addr, logic [7:0] pr);
        tlpq_pkg::t_job j;
        j = '{bid, sid, addr, pr};
        i_start        <= 1'b1;
        i_req_type     <= rq;
        i_blk_id       <= bid;
        i_service_id   <= sid;
        i_ram_addr     <= addr;
        i_priority_req <= pr;
        do @(posedge i_clk); while (o_busy);
        sb.note_request(rq, j);
        if ($urandom_range(99) < idle_pct) pause($urandom_range(4, 1));
    endtask

    task pause(int n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // sender holds off until every outstanding response has come back
    task drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // mode write only with the queue idle; extra margin covers the back end's walk
    task write_mode(bit v);
        drain();
        repeat (tlpq_pkg::IMM_DEPTH + tlpq_pkg::STD_DEPTH + 6) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_mode(v);
        mode_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // small id pool so searches hit and priorities collide often
    task random_request();
        tlpq_pkg::t_req rq;
        logic [15:0] bid;
        logic [7:0]  pr;
        int          pick;
        pick = $urandom_range(99);
        rq = (pick < 40) ? tlpq_pkg::REQ_ENQ : (pick < 65) ? tlpq_pkg::REQ_DEQ
           : (pick < 80) ? tlpq_pkg::REQ_PEEK : tlpq_pkg::REQ_SEARCH;
        bid = ($urandom_range(99) < 60) ? 16'($urandom_range(15)) : 16'($urandom);
        pick = $urandom_range(99);
        pr = (pick < 25) ? 8'd0 : (pick < 65) ? 8'($urandom_range(4, 1)) : 8'($urandom);
        send_request(rq, bid, 8'($urandom), $urandom, pr);
    endtask

    initial begin
        idle_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty rings, immediate ring overflow, sorted insertion with
        // ties, standard ring overflow, field extremes, then FCFS with jobs held
        // in the immediate ring.
        send_request(tlpq_pkg::REQ_PEEK,   16'h0000, 8'h00, 32'h0, 8'h00);
        send_request(tlpq_pkg::REQ_DEQ,    16'h0000, 8'h00, 32'h0, 8'h00);
        send_request(tlpq_pkg::REQ_SEARCH, 16'h0000, 8'h00, 32'h0, 8'h00);
        for (int k = 0; k < tlpq_pkg::IMM_DEPTH + 1; k++)
            send_request(tlpq_pkg::REQ_ENQ, 16'(16'hFFF0 + k), 8'hFF, 32'hFFFF_FFFF,
                         8'h00);
        send_request(tlpq_pkg::REQ_ENQ, 16'h0001, 8'h11, 32'h1111_0000, 8'd200);
        send_request(tlpq_pkg::REQ_ENQ, 16'h0002, 8'h22, 32'h2222_0000, 8'd255);
        send_request(tlpq_pkg::REQ_ENQ, 16'h0003, 8'h33, 32'h3333_0000, 8'd5);
        send_request(tlpq_pkg::REQ_ENQ, 16'h0004, 8'h44, 32'h4444_0000, 8'd5);
        send_request(tlpq_pkg::REQ_ENQ, 16'h0005, 8'h55, 32'h5555_0000, 8'd1);
        for (int k = 0; k < 4; k++)
            send_request(tlpq_pkg::REQ_ENQ, 16'(16'h0010 + k), 8'h00, 32'h0, 8'd128);
        send_request(tlpq_pkg::REQ_SEARCH, 16'h0004, 8'h00, 32'h0, 8'h00);
        send_request(tlpq_pkg::REQ_SEARCH, 16'hFFF3, 8'h00, 32'h0, 8'h00);
        send_request(tlpq_pkg::REQ_SEARCH, 16'hABCD, 8'h00, 32'h0, 8'h00);
        send_request(tlpq_pkg::REQ_PEEK,   16'h0000, 8'h00, 32'h0, 8'h00);
        send_request(tlpq_pkg::REQ_DEQ,    16'h0000, 8'h00, 32'h0, 8'h00);
        write_mode(1'b0);
        send_request(tlpq_pkg::REQ_ENQ,  16'h7777, 8'h77, 32'h7777_7777, 8'h00);
        send_request(tlpq_pkg::REQ_PEEK, 16'h0000, 8'h00, 32'h0, 8'h00);

        // Random phases: sender busy-ish, mostly idle, then back to back.
        // The mode is switched at the start and half way through each phase.
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 15 : (ph == 1) ? 81 : 0;
            write_mode(ph[0]);
            for (int n = 0; n < 530; n++) begin
                if (n == 265) write_mode(!ph[0]);
                if (n % 97 == 50) drain();
                // occasionally empty everything so the rings wrap from all states
                if ($urandom_range(199) == 0)
                    repeat (tlpq_pkg::IMM_DEPTH + tlpq_pkg::STD_DEPTH)
                        send_request(tlpq_pkg::REQ_DEQ, 16'($urandom), 8'($urandom),
                                     $urandom, 8'($urandom));
                random_request();
            end
        end

        drain();
        repeat (tlpq_pkg::IMM_DEPTH + tlpq_pkg::STD_DEPTH + 10) @(posedge i_clk);
        $display("covered %0d enqueue, %0d dequeue, %0d peek, %0d search requests",
                 sb.req_seen[tlpq_pkg::REQ_ENQ], sb.req_seen[tlpq_pkg::REQ_DEQ],
                 sb.req_seen[tlpq_pkg::REQ_PEEK], sb.req_seen[tlpq_pkg::REQ_SEARCH]);
        $display("%0d responses compared across %0d mode writes", sb.checked, mode_writes);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

>>> filelist.f
sv/tlpq_pkg.sv
sv/tlpq_front.sv
sv/tlpq_cmdq.sv
sv/tlpq_back.sv
sv/two_level_priority_job_queue.sv
tb/sv/testbench.sv
